>>> rtl/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants of the line edit buffer
// Payload structs, cell control, register indexes and key constants.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int BUFFER_SIZE_DEF = 64;
    // widest position held in a cell's control (BUFFER_SIZE up to 256)
    localparam int POS_W_MAX       = 8;
    localparam int IDX_W           = 6;
    localparam int CODE_W          = 16;
    localparam int CHAR_W          = 8;
    localparam int CFG_IDX_W       = 2;

    localparam logic signed [CODE_W-1:0] KEY_BACKSPACE   = 16'sd8;
    localparam logic signed [CODE_W-1:0] FIRST_PRINTABLE = 16'sd32;

    localparam logic signed [CODE_W-1:0] CODE_LEFT_RST  = -16'sd20;
    localparam logic signed [CODE_W-1:0] CODE_RIGHT_RST = -16'sd18;
    localparam logic signed [CODE_W-1:0] CODE_END_RST   = -16'sd17;
    localparam logic signed [CODE_W-1:0] CODE_HOME_RST  = -16'sd19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_LEFT  = 2'd0,
        REG_CODE_RIGHT = 2'd1,
        REG_CODE_END   = 2'd2,
        REG_CODE_HOME  = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [POS_W_MAX-1:0]   cursor;
        logic [CHAR_W-1:0]      ch;
        logic [POS_W_MAX-1:0]   rd_idx;
    } t_cell_ctrl;

    typedef struct packed {
        logic                      kind;
        logic signed [CODE_W-1:0]  key_code;
        logic [IDX_W-1:0]          read_index;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   cursor_pos;
        logic [IDX_W-1:0]   text_length;
        logic [CHAR_W-1:0]  read_char;
        logic               dropped;
    } t_out_item;

endpackage

>>> rtl/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer: one-line text edit buffer with cursor
// Key events edit the text or move the cursor; read events return a byte.
// ----------------------------------------------------------------------------
// An accepted item's result lands in the output register the next cycle; a
// new beat is accepted whenever that register is empty or is being drained,
// so the block sustains one item per clock. The text lives in BUFFER_SIZE
// byte cells that shift the tail right on an insert and left on a backspace
// as the item is taken; a read picks the addressed cell by an AND-OR over the
// row. At most BUFFER_SIZE-1 characters are held. The user must write the key
// code registers via the configuration port only while idle; not enforced.
module line_edit_buffer #(
    parameter int BUFFER_SIZE = leb_pkg::BUFFER_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  leb_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output leb_pkg::t_out_item             o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [leb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [leb_pkg::CODE_W-1:0]     i_cfg_data
);
    import leb_pkg::*;

    localparam int PW = $clog2(BUFFER_SIZE);
    localparam int IW = (PW > IDX_W) ? PW : IDX_W;
    localparam logic [PW-1:0] CAPACITY = PW'(BUFFER_SIZE - 1);

    logic signed [CODE_W-1:0] r_code_left, r_code_right, r_code_end, r_code_home;
    logic [PW-1:0]            r_cursor, n_cursor;
    logic [PW-1:0]            r_length, n_length;
    logic                     r_out_valid;
    t_out_item                r_out;

    t_cell_ctrl               w_ctrl;
    t_cell_op                 w_op;
    logic                     w_drop;
    logic                     w_accept;
    logic                     w_rd_ok;
    logic [CHAR_W-1:0]        w_rd_char;
    logic signed [CODE_W-1:0] w_key;
    logic [CHAR_W-1:0]        w_char    [BUFFER_SIZE];
    logic [CHAR_W-1:0]        w_rd      [BUFFER_SIZE];

    // nothing is taken while reset is held
    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_key       = i_in.key_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_left  <= CODE_LEFT_RST;
            r_code_right <= CODE_RIGHT_RST;
            r_code_end   <= CODE_END_RST;
            r_code_home  <= CODE_HOME_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CODE_LEFT:  r_code_left  <= i_cfg_data;
                REG_CODE_RIGHT: r_code_right <= i_cfg_data;
                REG_CODE_END:   r_code_end   <= i_cfg_data;
                REG_CODE_HOME:  r_code_home  <= i_cfg_data;
                default:        r_code_left  <= r_code_left;
            endcase
        end
    end

    // key decode, in priority order
    always_comb begin
        n_cursor = r_cursor;
        n_length = r_length;
        w_op     = CELL_HOLD;
        w_drop   = 1'b0;
        if (!i_in.kind) begin
            if (w_key == KEY_BACKSPACE) begin
                if (r_cursor != '0) begin
                    w_op     = CELL_DELETE;
                    n_cursor = r_cursor - 1'b1;
                    n_length = r_length - 1'b1;
                end
            end else if (w_key >= FIRST_PRINTABLE) begin
                if (r_length >= CAPACITY) begin
                    w_drop = 1'b1;
                end else begin
                    w_op     = CELL_INSERT;
                    n_cursor = r_cursor + 1'b1;
                    n_length = r_length + 1'b1;
                end
            end else if (w_key == r_code_left) begin
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - 1'b1;
                end
            end else if (w_key == r_code_right) begin
                if (r_cursor < r_length) begin
                    n_cursor = r_cursor + 1'b1;
                end
            end else if (w_key == r_code_end) begin
                n_cursor = r_length;
            end else if (w_key == r_code_home) begin
                n_cursor = '0;
            end
        end
    end

    always_comb begin
        w_ctrl.op     = w_accept ? w_op : CELL_HOLD;
        w_ctrl.cursor = POS_W_MAX'(r_cursor);
        w_ctrl.ch     = w_key[CHAR_W-1:0];
        w_ctrl.rd_idx = POS_W_MAX'(i_in.read_index);
    end

    for (genvar g = 0; g < BUFFER_SIZE; g++) begin : g_cell
        logic [CHAR_W-1:0] w_left;
        logic [CHAR_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_char[g-1];
        end
        if (g == BUFFER_SIZE - 1) begin : g_last
            assign w_right = w_char[g];
        end else begin : g_inner
            assign w_right = w_char[g+1];
        end
        leb_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_left_char  (w_left),
            .i_right_char (w_right),
            .o_char       (w_char[g]),
            .o_rd_char    (w_rd[g])
        );
    end

    assign w_rd_ok = IW'(i_in.read_index) < IW'(r_length);

    always_comb begin
        w_rd_char = '0;
        for (int k = 0; k < BUFFER_SIZE; k++) begin
            w_rd_char = w_rd_char | w_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cursor    <= n_cursor;
                r_length    <= n_length;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.cursor_pos  <= IDX_W'(n_cursor);
            r_out.text_length <= IDX_W'(n_length);
            r_out.read_char   <= (i_in.kind && w_rd_ok) ? w_rd_char : '0;
            r_out.dropped     <= w_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/leb_cell.sv
// ----------------------------------------------------------------------------
// leb_cell: one character position of the edit buffer
// Holds a byte; loads the new byte, takes its left neighbour on an insert or
// its right neighbour on a delete, and offers its byte when read.
// ----------------------------------------------------------------------------
module leb_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  leb_pkg::t_cell_ctrl         i_ctrl,
    input  logic [leb_pkg::CHAR_W-1:0]  i_left_char,
    input  logic [leb_pkg::CHAR_W-1:0]  i_right_char,
    output logic [leb_pkg::CHAR_W-1:0]  o_char,
    output logic [leb_pkg::CHAR_W-1:0]  o_rd_char
);
    import leb_pkg::*;

    localparam logic [POS_W_MAX-1:0] MY_IDX = POS_W_MAX'(IDX);

    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;

    always_comb begin
        n_char = r_char;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (MY_IDX == i_ctrl.cursor) begin
                    n_char = i_ctrl.ch;
                end else if (MY_IDX > i_ctrl.cursor) begin
                    n_char = i_left_char;
                end
            end
            CELL_DELETE: begin
                // cursor is non-zero here: close the gap at cursor-1
                if (MY_IDX >= i_ctrl.cursor - 1'b1) begin
                    n_char = i_right_char;
                end
            end
            default: n_char = r_char;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char    = r_char;
    assign o_rd_char = (MY_IDX == i_ctrl.rd_idx) ? r_char : '0;

endmodule
